/* design/mhpq_pkg.sv */
// Package for the min-heap priority queue: command and status codes,
// request and response payload types. No dependencies.
`default_nettype none
package mhpq_pkg;
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam int TOTAL_W = 11;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] key;
    } req_t;

    typedef struct packed {
        logic [1:0]           status;
        logic                 min_valid;
        logic signed [31:0]   min_key;
        logic [TOTAL_W-1:0]   entry_total;
    } rsp_t;
endpackage
`default_nettype wire

/* design/mhpq_if.sv */
// Valid/ready channel interfaces for requests and responses.
// Depends on mhpq_pkg.
`default_nettype none
interface mhpq_req_if import mhpq_pkg::*; ();
    logic valid;
    logic ready;
    logic [1:0] cmd;
    logic signed [31:0] key;
    modport source (output valid, output cmd, output key, input ready);
    modport sink (input valid, input cmd, input key, output ready);
endinterface

interface mhpq_rsp_if import mhpq_pkg::*; ();
    logic valid;
    logic ready;
    logic [1:0] status;
    logic min_valid;
    logic signed [31:0] min_key;
    logic [TOTAL_W-1:0] entry_total;
    modport source (output valid, output status, output min_valid, output min_key,
                    output entry_total, input ready);
    modport sink (input valid, input status, input min_valid, input min_key,
                  input entry_total, output ready);
endinterface
`default_nettype wire

/* design/mhpq_ram.sv */
// Single-port-write, single-port-read heap store, registered read data.
// No dependencies.
`default_nettype none
module mhpq_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [31:0]   wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [31:0]   rdata
);
    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* design/min_heap_priority_queue.sv */
// Min-heap priority queue over a synchronous heap store.
// Query reads the root; insert sifts the new key up from the end; delete does a
// linear scan for the key, moves the last entry into its slot, then sifts it
// up or, if it did not move up, down. One request in flight at a time. Reset
// clears the entry count and control state; the store itself is not cleared
// and its contents are used only below the count.
`default_nettype none
module min_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input wire logic  clk,
    input wire logic  rst_n,
    mhpq_req_if.sink   req,
    mhpq_rsp_if.source rsp
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_LAST_RD, S_LAST_WR,
        S_UP_RD, S_UP_CMP, S_DN_RDL, S_DN_RDR, S_DN_CMP, S_ROOT_RD, S_ROOT_WT, S_RESP
    } state_t;

    state_t state_reg;
    logic [CW-1:0] count_reg;
    logic [1:0] cmd_reg;
    logic [31:0] key_reg;
    logic [CW-1:0] pos_reg;   // slot of moving key
    logic [31:0] cur_reg;     // value of moving key
    logic [31:0] lval_reg;
    logic lok_reg;
    logic [CW-1:0] scan_reg;
    logic [1:0] status_reg;
    logic [31:0] min_reg;
    logic moved_reg;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0] wdata, rdata;

    mhpq_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    function automatic logic kless(input logic [31:0] a, input logic [31:0] b);
        kless = $signed(a) < $signed(b);
    endfunction

    // Index helpers, widened by one bit to avoid overflow.
    logic [CW:0] parent_w, left_w, right_w;
    assign parent_w = ({1'b0, pos_reg} - 1'b1) >> 1;
    assign left_w   = {pos_reg, 1'b1};
    assign right_w  = {pos_reg, 1'b0} + 2'd2;

    // Down-step choice: smaller in-range child, if smaller than cur.
    logic l_in, r_in, take_l, take_r;
    assign l_in = left_w < (CW+1)'(count_reg);
    assign r_in = right_w < (CW+1)'(count_reg);
    always_comb
    begin
        take_l = l_in && kless(lval_reg, cur_reg);
        take_r = r_in && kless(rdata, cur_reg) && !(take_l && !kless(rdata, lval_reg));
        if (take_r)
        begin
            take_l = 1'b0;
        end
    end

    // Child value that moves up into pos on a down step.
    logic [31:0] dn_child;
    assign dn_child = take_r ? rdata : lval_reg;

    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = cur_reg;
        raddr = '0;
        case (state_reg)
            S_SCAN_RD:  raddr = scan_reg[AW-1:0];
            S_LAST_RD:  raddr = AW'(count_reg - 1'b1);
            S_UP_RD:    raddr = parent_w[AW-1:0];
            S_DN_RDL:   raddr = left_w[AW-1:0];
            S_DN_RDR:   raddr = right_w[AW-1:0];
            S_ROOT_RD:  raddr = '0;
            default:    raddr = '0;
        endcase
        // Write into the moving key's slot: the last entry, a parent or child that moves, or the key when it settles.
        if (state_reg == S_LAST_WR)
        begin
            we    = 1'b1;         // copy the last entry into the vacated slot
            waddr = pos_reg[AW-1:0];
            wdata = rdata;
        end
        else if (state_reg == S_UP_CMP && pos_reg != '0 && kless(cur_reg, rdata))
        begin
            we    = 1'b1;         // move parent down into this slot
            waddr = pos_reg[AW-1:0];
            wdata = rdata;
        end
        else if (state_reg == S_DN_CMP)
        begin
            we    = 1'b1;
            waddr = pos_reg[AW-1:0];
            if (lok_reg && (take_l || take_r))
            begin
                wdata = dn_child; // move the chosen child up into this slot
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            status_reg <= ST_OK;
            moved_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        cmd_reg <= req.cmd;
                        key_reg <= req.key;
                        status_reg <= ST_OK;
                        scan_reg <= '0;
                        moved_reg <= 1'b0;
                        if (req.cmd == CMD_INSERT)
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                status_reg <= ST_FULL;
                                state_reg <= S_ROOT_RD;
                            end
                            else
                            begin
                                pos_reg <= count_reg;
                                cur_reg <= req.key;
                                count_reg <= count_reg + 1'b1;
                                state_reg <= S_UP_RD;
                            end
                        end
                        else if (req.cmd == CMD_DELETE)
                        begin
                            state_reg <= S_SCAN_RD;
                        end
                        else
                        begin
                            state_reg <= S_ROOT_RD;
                        end
                    end
                end
                S_SCAN_RD:
                begin
                    if (scan_reg >= count_reg)
                    begin
                        status_reg <= ST_NOTFOUND;
                        state_reg <= S_ROOT_RD;
                    end
                    else
                    begin
                        state_reg <= S_SCAN_CHK;
                    end
                end
                S_SCAN_CHK:
                begin
                    if (rdata == key_reg)
                    begin
                        pos_reg <= scan_reg;
                        state_reg <= S_LAST_RD;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + 1'b1;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_LAST_RD:
                begin
                    count_reg <= count_reg - 1'b1;
                    state_reg <= S_LAST_WR;
                end
                S_LAST_WR:
                begin
                    // rdata holds the last entry; it becomes the moving key.
                    cur_reg <= rdata;
                    if (pos_reg >= count_reg)
                    begin
                        state_reg <= S_ROOT_RD;
                    end
                    else
                    begin
                        state_reg <= S_UP_RD;
                    end
                end
                S_UP_RD:
                begin
                    state_reg <= S_UP_CMP;
                end
                S_UP_CMP:
                begin
                    if (pos_reg != '0 && kless(cur_reg, rdata))
                    begin
                        pos_reg <= parent_w[CW-1:0];
                        moved_reg <= 1'b1;
                        state_reg <= S_UP_RD;
                    end
                    else if (cmd_reg == CMD_DELETE && !moved_reg)
                    begin
                        state_reg <= S_DN_RDL;
                    end
                    else
                    begin
                        state_reg <= S_DN_CMP; // write cur, no down move
                        lok_reg <= 1'b0;
                    end
                end
                S_DN_RDL:
                begin
                    state_reg <= S_DN_RDR;
                    lok_reg <= 1'b1;
                end
                S_DN_RDR:
                begin
                    lval_reg <= rdata;
                    state_reg <= S_DN_CMP;
                end
                S_DN_CMP:
                begin
                    // lok_reg marks a real down step; otherwise this is the final write.
                    if (lok_reg && take_l)
                    begin
                        state_reg <= S_DN_RDL;
                        pos_reg <= left_w[CW-1:0];
                        lok_reg <= 1'b0;
                    end
                    else if (lok_reg && take_r)
                    begin
                        state_reg <= S_DN_RDL;
                        pos_reg <= right_w[CW-1:0];
                        lok_reg <= 1'b0;
                    end
                    else if (lok_reg)
                    begin
                        lok_reg <= 1'b0; // write cur at pos
                    end
                    else
                    begin
                        state_reg <= S_ROOT_RD;
                    end
                end
                S_ROOT_RD:
                begin
                    state_reg <= S_ROOT_WT;
                end
                S_ROOT_WT:
                begin
                    min_reg <= rdata;
                    state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    if (rsp.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = (state_reg == S_RESP);
    assign rsp.status = status_reg;
    assign rsp.min_valid = (count_reg != '0);
    assign rsp.min_key = (count_reg != '0) ? min_reg : '0;
    assign rsp.entry_total = TOTAL_W'(count_reg);

    // Count never exceeds the store depth.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH)) else $error("entry count overflow");
    // A request is taken only while no response is pending.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && rsp.valid)) else $error("request accepted during response");
    // A full status is reported only while the count is at the store depth.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_FULL) |-> count_reg == CW'(DEPTH))
        else $error("full status with free space");
endmodule
`default_nettype wire
